FILE: rtl/core/timed_midi_event_table_unit_macros.svh
// assertion macros for the timed midi event table unit
`ifndef TIMED_MIDI_EVENT_TABLE_UNIT_MACROS_SVH
`define TIMED_MIDI_EVENT_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define TMET_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define TMET_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TMET_ASSERT(label, clk, rst, prop)
`define TMET_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/core/tmet_pkg.sv
// ----------------------------------------------------------------------------
// tmet_pkg
// shared types and constants of the timed midi event table
// ----------------------------------------------------------------------------
package tmet_pkg;
   localparam int TableDepth = 64;
   localparam int MaxResults = 64;
   localparam int CountW = $clog2(TableDepth + 1);
   localparam int ResW = $clog2(MaxResults + 1);

   localparam logic [1:0] CMD_NOTE = 2'd0;
   localparam logic [1:0] CMD_CONTROL = 2'd1;
   localparam logic [1:0] CMD_PROGRAM = 2'd2;
   localparam logic [1:0] CMD_PLAY = 2'd3;

   localparam logic [1:0] KIND_PLAYED = 2'd0;
   localparam logic [1:0] KIND_STORED = 2'd1;
   localparam logic [1:0] KIND_DROPPED = 2'd2;

   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON = 4'h9;
   localparam logic [3:0] ST_CONTROL = 4'hB;
   localparam logic [3:0] ST_PROGRAM = 4'hC;
   localparam logic [7:0] CTRL_BANK = 8'h00;
   localparam logic [3:0] CHAN_MASK = 4'hF;

   typedef struct packed {
      logic [31:0] time_val;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
   } event_type;

   // broadcast to every cell in the same cycle
   typedef struct packed {
      logic       ins;
      event_type  ev;
   } ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INS_A, S_INS_B, S_SCAN, S_RESP
   } state_type;
endpackage

FILE: rtl/core/tmet_cell.sv
// ----------------------------------------------------------------------------
// tmet_cell
// one slot of the sorted table; shifts up on insert and towards the head on scan
// ----------------------------------------------------------------------------
module tmet_cell (
   input  logic                clock,
   input  tmet_pkg::ctrl_type  ctrl,
   input  logic                scan,
   input  logic                here_valid,
   input  logic                prev_valid,
   input  logic                prev_goes_before,
   input  tmet_pkg::event_type prev_ev,
   input  tmet_pkg::event_type next_ev,
   output logic                goes_before,
   output tmet_pkg::event_type ev
);
   import tmet_pkg::*;
   event_type ev_ff, ev_in;

   // new event lands before this slot when its time is strictly earlier
   assign goes_before = here_valid & (ctrl.ev.time_val < ev_ff.time_val);

   always_comb begin
      ev_in = ev_ff;
      if (scan) begin
         ev_in = next_ev; // rotate towards the head
      end else if (ctrl.ins) begin
         // lower neighbour moves up when the new event lands below this slot
         if (prev_valid && prev_goes_before) ev_in = prev_ev;
         // first later entry, or the first free slot, takes the new event
         else if (goes_before || (!here_valid && prev_valid)) ev_in = ctrl.ev;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end
   assign ev = ev_ff;
endmodule

FILE: rtl/core/timed_midi_event_table_unit.sv
// ----------------------------------------------------------------------------
// timed_midi_event_table_unit
// time-sorted midi event table held in a shifting row of cells
// ----------------------------------------------------------------------------
// Adds pass through S_INS_A, and through S_INS_B as well when they store two
// events, before S_RESP registers the answer: the event enters every cell at
// once and each cell either keeps its entry, takes the new one or takes its
// lower neighbour. A play rotates the stored entries once through the head cell,
// one entry a cycle while the result side does not stall. One item is in work at
// a time; the next is taken the cycle after the last result of the previous one
// has left.
`include "timed_midi_event_table_unit_macros.svh"
module timed_midi_event_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_time_req,
   input  logic [3:0]  req_channel,
   input  logic [7:0]  req_key_byte,
   input  logic [7:0]  req_value_byte,
   input  logic [31:0] req_duration,
   input  logic [31:0] req_window_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_offset,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_data_one,
   output logic [7:0]  rsp_data_two,
   output logic        rsp_last
);
   import tmet_pkg::*;

   state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in, scan_cnt_ff, scan_cnt_in;
   logic [ResW-1:0] emitted_ff, emitted_in;
   logic [1:0] cmd_ff;
   logic [31:0] t_ff, dur_ff;
   logic [3:0] ch_ff;
   logic [7:0] key_ff, val_ff;
   logic [32:0] end_ff;
   // pending match held until the next one is known, so last can be set
   logic hold_ff, hold_in;
   event_type hold_ev_ff, hold_ev_in;
   logic out_v_ff, out_v_in;
   logic [1:0] o_kind_ff, o_kind_in;
   logic [31:0] o_off_ff, o_off_in;
   logic [7:0] o_s_ff, o_s_in, o_d1_ff, o_d1_in, o_d2_ff, o_d2_in;
   logic o_last_ff, o_last_in;
   logic stored_ff;

   ctrl_type ctrl;
   logic scan;
   logic [TableDepth-1:0] valid, gb;
   event_type evs [TableDepth];
   logic head_match, scan_fin;
   logic [1:0] need;

   // the last valid slot takes the head entry, so count_ff steps bring the
   // stored entries back to order; the head sees a valid lower neighbour
   // that never goes before
   for (genvar i = 0; i < TableDepth; i++) begin : g_cell
      assign valid[i] = (CountW'(i) < count_ff);
      tmet_cell u_cell (
         .clock            (clock),
         .ctrl             (ctrl),
         .scan             (scan),
         .here_valid       (valid[i]),
         .prev_valid       ((i == 0) ? 1'b1 : valid[(i == 0) ? 0 : i-1]),
         .prev_goes_before ((i == 0) ? 1'b0 : gb[(i == 0) ? 0 : i-1]),
         .prev_ev          (evs[(i == 0) ? 0 : i-1]),
         .next_ev          ((i == TableDepth-1 ||
                             (valid[i] && !valid[(i == TableDepth-1) ? i : i+1]))
                            ? evs[0] : evs[(i == TableDepth-1) ? 0 : i+1]),
         .goes_before      (gb[i]),
         .ev               (evs[i])
      );
   end

   assign need = (cmd_ff == CMD_CONTROL) ? 2'd1 : 2'd2;
   assign head_match = (count_ff != '0) && ({1'b0, evs[0].time_val} >= {1'b0, t_ff})
                       && ({1'b0, evs[0].time_val} < end_ff);
   assign scan_fin = (scan_cnt_ff == count_ff);
   assign req_ready = (state_ff == S_IDLE) && !out_v_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            state_in = (req_command == CMD_PLAY) ? S_SCAN : S_INS_A;
         end
         S_INS_A: begin
            if ({1'b0, count_ff} + CountW'(need) > CountW'(TableDepth)) state_in = S_RESP;
            else if (cmd_ff == CMD_CONTROL) state_in = S_RESP;
            else state_in = S_INS_B;
         end
         S_INS_B: state_in = S_RESP;
         S_RESP: if (!out_v_ff || rsp_ready) state_in = S_IDLE;
         S_SCAN: if (scan_fin && (!out_v_ff || rsp_ready)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      scan = 1'b0;
      count_in = count_ff;
      scan_cnt_in = scan_cnt_ff;
      emitted_in = emitted_ff;
      hold_in = hold_ff;
      hold_ev_in = hold_ev_ff;
      out_v_in = out_v_ff && !rsp_ready;
      o_kind_in = o_kind_ff; o_off_in = o_off_ff; o_s_in = o_s_ff;
      o_d1_in = o_d1_ff; o_d2_in = o_d2_ff; o_last_in = o_last_ff;
      case (state_ff)
         S_IDLE: begin
            scan_cnt_in = '0; emitted_in = '0; hold_in = 1'b0;
         end
         S_INS_A: if (state_in != S_RESP || cmd_ff == CMD_CONTROL) begin
            ctrl.ins = 1'b1;
            ctrl.ev.time_val = t_ff;
            case (cmd_ff)
               CMD_NOTE: ctrl.ev = {t_ff, ST_NOTE_ON, ch_ff & CHAN_MASK, key_ff, val_ff};
               CMD_CONTROL: ctrl.ev = {t_ff, ST_CONTROL, ch_ff, key_ff, val_ff};
               default: ctrl.ev = {t_ff, ST_CONTROL, ch_ff, CTRL_BANK, key_ff};
            endcase
            if ({1'b0, count_ff} + CountW'(need) > CountW'(TableDepth)) ctrl.ins = 1'b0;
            else count_in = count_ff + 1'b1;
         end
         S_INS_B: begin
            ctrl.ins = 1'b1;
            case (cmd_ff)
               CMD_NOTE: ctrl.ev = {t_ff + dur_ff, ST_NOTE_OFF, ch_ff, key_ff, val_ff};
               default: ctrl.ev = {t_ff, ST_PROGRAM, ch_ff, val_ff, 8'h00};
            endcase
            count_in = count_ff + 1'b1;
         end
         S_RESP: if (!out_v_ff || rsp_ready) begin
            out_v_in = 1'b1;
            o_kind_in = stored_ff ? KIND_STORED : KIND_DROPPED;
            o_off_in = '0; o_s_in = '0; o_d1_in = '0; o_d2_in = '0; o_last_in = 1'b1;
         end
         S_SCAN: if (!out_v_ff || rsp_ready) begin
            if (!scan_fin) begin
               scan = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
               if (head_match && emitted_ff < ResW'(MaxResults)) begin
                  emitted_in = emitted_ff + 1'b1;
                  hold_in = 1'b1;
                  hold_ev_in = evs[0];
                  if (hold_ff) begin
                     out_v_in = 1'b1; o_last_in = 1'b0;
                  end
               end
            end else if (hold_ff) begin
               out_v_in = 1'b1; o_last_in = 1'b1; hold_in = 1'b0;
            end
            if (out_v_in && !(out_v_ff && !rsp_ready)) begin
               o_kind_in = KIND_PLAYED;
               o_off_in = hold_ev_ff.time_val - t_ff;
               o_s_in = hold_ev_ff.b0; o_d1_in = hold_ev_ff.b1; o_d2_in = hold_ev_ff.b2;
            end
         end
         default: ;
      endcase
   end

   // remembers whether the add went in, for the answer
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) stored_ff <= 1'b0;
      else if (ctrl.ins) stored_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; out_v_ff <= 1'b0; hold_ff <= 1'b0;
         scan_cnt_ff <= '0; emitted_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; out_v_ff <= out_v_in;
         hold_ff <= hold_in; scan_cnt_ff <= scan_cnt_in; emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_command; t_ff <= req_time_req; ch_ff <= req_channel;
         key_ff <= req_key_byte; val_ff <= req_value_byte; dur_ff <= req_duration;
         end_ff <= {1'b0, req_time_req} + {1'b0, req_window_length};
      end
      hold_ev_ff <= hold_ev_in;
      o_kind_ff <= o_kind_in; o_off_ff <= o_off_in; o_s_ff <= o_s_in;
      o_d1_ff <= o_d1_in; o_d2_ff <= o_d2_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_offset = o_off_ff;
   assign rsp_status_byte = o_s_ff;
   assign rsp_data_one = o_d1_ff;
   assign rsp_data_two = o_d2_ff;
   assign rsp_last = o_last_ff;

   `TMET_ASSERT(a_count_bound, clock, reset, count_ff <= CountW'(TableDepth))
   `TMET_ASSERT(a_busy_not_ready, clock, reset, (state_ff != S_IDLE) |-> !req_ready)
   `TMET_ASSERT(a_add_single, clock, reset,
      (rsp_valid && rsp_kind != KIND_PLAYED) |-> rsp_last)
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the timed midi event table against its own sorted event list, with a
// directed table of adds and plays first, then random adds and windows under
// bursty input and a stalling result side
// ----------------------------------------------------------------------------
module testbench;
   import tmet_pkg::*;

   localparam int IdleLimit = 20000;
   localparam int NumRows = 22;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] time_req;
      logic [3:0]  channel;
      logic [7:0]  key_byte;
      logic [7:0]  value_byte;
      logic [31:0] duration;
      logic [31:0] window_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] offset;
      logic [7:0]  status_byte;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic        last;
   } rsp_item_type;

   // directed row: item plus optional typed-in answer
   typedef struct packed {
      req_item_type item;
      logic         has_answer;
      rsp_item_type answer;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [31:0] req_time_req;
   logic [3:0]  req_channel;
   logic [7:0]  req_key_byte;
   logic [7:0]  req_value_byte;
   logic [31:0] req_duration;
   logic [31:0] req_window_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_offset;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_data_one;
   logic [7:0]  rsp_data_two;
   logic        rsp_last;

   timed_midi_event_table_unit DUT (.*);

   event_type    sorted_events[$];
   rsp_item_type pending_rsp[$];
   row_type      rows[NumRows];
   int           mismatches;
   int           idle_cycles;
   bit           hold_off;
   bit           stim_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stable insert after equal times
   function automatic void insert_event(event_type ev);
      int pos;
      pos = sorted_events.size();
      for (int i = 0; i < sorted_events.size(); i++) begin
         if (ev.time_val < sorted_events[i].time_val) begin
            pos = i;
            break;
         end
      end
      sorted_events.insert(pos, ev);
   endfunction

   function automatic void predict_table(req_item_type it);
      rsp_item_type r;
      logic [32:0] win_end;
      int n;
      int need;
      r = '0;
      if (it.command == CMD_PLAY) begin
         win_end = {1'b0, it.time_req} + {1'b0, it.window_length};
         n = 0;
         foreach (sorted_events[i]) begin
            if (n < MaxResults && sorted_events[i].time_val >= it.time_req &&
                {1'b0, sorted_events[i].time_val} < win_end) begin
               r.kind = KIND_PLAYED;
               r.offset = sorted_events[i].time_val - it.time_req;
               r.status_byte = sorted_events[i].b0;
               r.data_one = sorted_events[i].b1;
               r.data_two = sorted_events[i].b2;
               r.last = 1'b0;
               pending_rsp.push_back(r);
               n++;
            end
         end
         if (n > 0) pending_rsp[$].last = 1'b1;
         return;
      end
      need = (it.command == CMD_CONTROL) ? 1 : 2;
      r.last = 1'b1;
      if (sorted_events.size() + need > TableDepth) begin
         r.kind = KIND_DROPPED;
      end else begin
         r.kind = KIND_STORED;
         case (it.command)
            CMD_NOTE: begin
               insert_event({it.time_req, ST_NOTE_ON, it.channel, it.key_byte,
                             it.value_byte});
               insert_event({it.time_req + it.duration, ST_NOTE_OFF, it.channel,
                             it.key_byte, it.value_byte});
            end
            CMD_CONTROL: begin
               insert_event({it.time_req, ST_CONTROL, it.channel, it.key_byte,
                             it.value_byte});
            end
            default: begin
               insert_event({it.time_req, ST_CONTROL, it.channel, CTRL_BANK,
                             it.key_byte});
               insert_event({it.time_req, ST_PROGRAM, it.channel, it.value_byte,
                             8'h00});
            end
         endcase
      end
      pending_rsp.push_back(r);
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int sel;
      it.channel = 4'($urandom);
      it.key_byte = 8'($urandom);
      it.value_byte = 8'($urandom);
      // times mostly in a narrow band so windows hit, sometimes anywhere in 32 bits
      it.time_req = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400);
      it.duration = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100);
      it.window_length = ($urandom_range(0, 9) == 0) ? $urandom
                                                      : $urandom_range(0, 300);
      sel = $urandom_range(0, 9);
      if (sel < 4) it.command = CMD_NOTE;
      else if (sel < 6) it.command = CMD_CONTROL;
      else if (sel < 7) it.command = CMD_PROGRAM;
      else it.command = CMD_PLAY;
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(req_item_type it);
      req_valid = 1'b1;
      {req_command, req_time_req, req_channel, req_key_byte, req_value_byte,
       req_duration, req_window_length} = it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table(it);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic row_type mk_row(logic [1:0] c, logic [31:0] t, logic [3:0] ch,
                                      logic [7:0] k, logic [7:0] v, logic [31:0] d,
                                      logic [31:0] w, logic has, logic [1:0] kind);
      row_type rw;
      rw.item = {c, t, ch, k, v, d, w};
      rw.has_answer = has;
      rw.answer = '0;
      rw.answer.kind = kind;
      rw.answer.last = 1'b1;
      return rw;
   endfunction

   initial begin
      rows[0]  = mk_row(CMD_PLAY, 32'd0, 4'h0, 8'h00, 8'h00, 32'd0, '1, 1'b0,
                        KIND_PLAYED);
      rows[1]  = mk_row(CMD_NOTE, 32'd10, 4'hF, 8'hFF, 8'hFF, 32'd5, 32'd0, 1'b1,
                        KIND_STORED);
      rows[2]  = mk_row(CMD_NOTE, 32'd10, 4'h0, 8'h00, 8'h00, 32'd0, 32'd0, 1'b1,
                        KIND_STORED);
      rows[3]  = mk_row(CMD_CONTROL, 32'd10, 4'hA, 8'h55, 8'hAA, 32'd0, 32'd0,
                        1'b1, KIND_STORED);
      rows[4]  = mk_row(CMD_PROGRAM, 32'd12, 4'h5, 8'hAA, 8'h55, 32'd0, 32'd0,
                        1'b1, KIND_STORED);
      rows[5]  = mk_row(CMD_NOTE, '1, 4'h3, 8'h3C, 8'h64, 32'd2, 32'd0, 1'b1,
                        KIND_STORED);
      rows[6]  = mk_row(CMD_NOTE, 32'hFFFF_FFF0, 4'h1, 8'h40, 8'h7F, '1, 32'd0,
                        1'b1, KIND_STORED);
      rows[7]  = mk_row(CMD_PLAY, 32'd10, 4'h0, 8'h00, 8'h00, 32'd0, 32'd0, 1'b0,
                        KIND_PLAYED);
      rows[8]  = mk_row(CMD_PLAY, 32'd10, 4'h0, 8'h00, 8'h00, 32'd0, 32'd1, 1'b0,
                        KIND_PLAYED);
      rows[9]  = mk_row(CMD_PLAY, 32'd0, 4'h0, 8'h00, 8'h00, 32'd0, 32'd20, 1'b0,
                        KIND_PLAYED);
      rows[10] = mk_row(CMD_PLAY, 32'hFFFF_FF00, 4'h0, 8'h00, 8'h00, 32'd0, '1,
                        1'b0, KIND_PLAYED);
      rows[11] = mk_row(CMD_PLAY, '1, 4'hF, 8'hFF, 8'hFF, '1, '1, 1'b0,
                        KIND_PLAYED);
      rows[12] = mk_row(CMD_PLAY, 32'd0, 4'h0, 8'h00, 8'h00, 32'd0, '1, 1'b0,
                        KIND_PLAYED);
      rows[13] = mk_row(CMD_PLAY, 32'd500, 4'h0, 8'h00, 8'h00, 32'd0, 32'd50,
                        1'b0, KIND_PLAYED);
      for (int i = 14; i < NumRows; i++)
         rows[i] = mk_row(CMD_CONTROL, 32'(i * 3), 4'(i), 8'(i), 8'(255 - i),
                          32'd0, 32'd0, 1'b0, KIND_STORED);
   end

   // stimulus
   initial begin
      req_item_type it;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_command, req_time_req, req_channel, req_key_byte, req_value_byte,
       req_duration, req_window_length} = '0;
      stim_done = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < NumRows; i++) begin
         send_item(rows[i].item);
         // typed-in answers must agree with the predicted one
         if (rows[i].has_answer && pending_rsp[$] != rows[i].answer) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", rows[i].answer,
                        pending_rsp[$]);
         end
      end
      req_valid = 1'b0;
      // table fills early, later adds are dropped and plays see a full row
      for (int n = 0; n < 300; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            it = random_item();
            send_item(it);
            n++;
         end
         req_valid = 1'b0;
         if ($urandom_range(0, 9) == 0) wait_drained();
         else repeat ($urandom_range(0, 6)) @(negedge clock);
         // whole-table plays once the table is full or one entry short of full
         if (sorted_events.size() >= TableDepth - 1 && $urandom_range(0, 3) == 0) begin
            it = random_item();
            it.command = CMD_PLAY;
            it.time_req = 32'd0;
            it.window_length = '1;
            send_item(it);
            req_valid = 1'b0;
         end
      end
      wait_drained();
      repeat (100) @(negedge clock);
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int cyc;
      rsp_ready = 1'b0;
      hold_off = 1'b0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 600) hold_off = 1'b1;
         if (cyc == 900) hold_off = 1'b0;
         if (hold_off) rsp_ready <= 1'b0;
         else if ((cyc / 200) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // checker and watchdog
   initial begin
      rsp_item_type got;
      rsp_item_type want;
      mismatches = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (stim_done) begin
            if (mismatches == 0 && pending_rsp.size() == 0) $display("tb: success");
            else $display("tb: failure");
            $finish;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_offset, rsp_status_byte, rsp_data_one,
                   rsp_data_two, rsp_last};
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item %h", got);
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end
endmodule
